@@ hw/rtl/tcps_pkg.sv @@
// ----------------------------------------------------------------------------
// tcps_pkg
// Shared types, codes and defaults for the two-class priority server.
// ----------------------------------------------------------------------------
package tcps_pkg;

  // default sizing, used as the top level's parameter defaults
  localparam int DEF_QUEUE_DEPTH = 64;
  localparam int DEF_TICK_BITS   = 16;

  // fixed field widths
  localparam int ID_W   = 16;
  localparam int SVC_W  = 4;
  localparam int OUT_TICK_W = 16;
  localparam int SUM_W  = 32;

  // server activity codes
  localparam logic [1:0] CLASS_IDLE = 2'd0;
  localparam logic [1:0] CLASS_PRIO = 2'd1;
  localparam logic [1:0] CLASS_NORM = 2'd2;

  // queue index: priority first
  localparam int Q_PRIO = 0;
  localparam int Q_NORM = 1;

  // input word
  typedef struct packed {
    logic             prio_arrives;
    logic [SVC_W-1:0] prio_service;
    logic             norm_arrives;
    logic [SVC_W-1:0] norm_service;
  } in_t;

  // output word
  typedef struct packed {
    logic [OUT_TICK_W-1:0] tick_now;
    logic [1:0]            serving_class;
    logic [ID_W-1:0]       serving_id;
    logic                  started;
    logic [OUT_TICK_W-1:0] start_wait;
    logic [SUM_W-1:0]      prio_wait_total;
    logic [SUM_W-1:0]      norm_wait_total;
    logic [ID_W-1:0]       prio_count;
    logic [ID_W-1:0]       norm_count;
    logic                  prio_dropped;
    logic                  norm_dropped;
  } out_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_FINISH
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;  // take the input word, enqueue arrivals
    logic read;    // read both queue heads
    logic finish;  // run the server step, load the output register
  } tcps_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_blocked;  // output register holds a word that is not taken now
  } tcps_sts_t;

endpackage

@@ hw/rtl/tcps_ram.sv @@
// ----------------------------------------------------------------------------
// tcps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/tcps_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcps_ctrl
// Sequencer: accept a word, read the queue heads, finish the server step.
// ----------------------------------------------------------------------------
module tcps_ctrl
  import tcps_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  tcps_sts_t sts,
  output tcps_cmd_t cmd
);

  ctrl_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!sts.out_blocked) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      ST_READ: begin
        cmd.read = 1'b1;
      end
      ST_FINISH: begin
        cmd.finish = !sts.out_blocked;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ hw/rtl/tcps_dp.sv @@
// ----------------------------------------------------------------------------
// tcps_dp
// Datapath: two queues in RAM, queue bookkeeping, server state, wait totals
// and the output register.
// ----------------------------------------------------------------------------
module tcps_dp
  import tcps_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int TICK_BITS   = DEF_TICK_BITS
) (
  input  logic      clk,
  input  logic      rst,
  input  in_t       in_word,
  input  tcps_cmd_t cmd,
  output tcps_sts_t sts,
  output logic      out_valid,
  input  logic      out_stall,
  output out_t      out_word
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int PW = AW + 1;
  localparam int EW = ID_W + TICK_BITS + SVC_W;

  // shared state
  logic [TICK_BITS-1:0] tick;
  logic [SVC_W-1:0]     remaining;
  logic [1:0]           cur_class;
  logic [ID_W-1:0]      cur_id;

  // per-queue state and views
  logic [AW-1:0]    head    [2];
  logic [FW-1:0]    fill    [2];
  logic [ID_W-1:0]  next_id [2];
  logic [ID_W-1:0]  count   [2];
  logic [SUM_W-1:0] sum     [2];
  logic [SUM_W-1:0] sum_sat [2];
  logic             dropped [2];
  logic [EW-1:0]    rdata   [2];
  logic             take    [2];
  logic             arrives [2];
  logic [SVC_W-1:0] service [2];

  assign arrives[Q_PRIO] = in_word.prio_arrives;
  assign arrives[Q_NORM] = in_word.norm_arrives;
  assign service[Q_PRIO] = in_word.prio_service;
  assign service[Q_NORM] = in_word.norm_service;

  // server choice: priority head first when the server is free
  logic idle_srv;
  assign idle_srv     = (remaining == '0);
  assign take[Q_PRIO] = idle_srv && (fill[Q_PRIO] != '0);
  assign take[Q_NORM] = idle_srv && (fill[Q_PRIO] == '0) && (fill[Q_NORM] != '0);

  // selected head entry and its wait
  logic [EW-1:0]        sel;
  logic [TICK_BITS-1:0] wait_ticks;
  logic [31:0]          wait_ext;
  logic [31:0]          tick_ext;
  assign sel        = take[Q_PRIO] ? rdata[Q_PRIO] : rdata[Q_NORM];
  assign wait_ticks = tick - sel[TICK_BITS+SVC_W-1:SVC_W];
  assign wait_ext   = 32'(wait_ticks);
  assign tick_ext   = 32'(tick);

  for (genvar q = 0; q < 2; q++) begin : g_queue
    logic [PW-1:0] pos_sum;
    logic [AW-1:0] wpos;
    logic [AW-1:0] head_inc;
    logic          full;
    logic [SUM_W:0] sum_wide;

    // write slot: (head + fill) mod depth, sum stays below twice the depth
    assign pos_sum  = PW'(head[q]) + PW'(fill[q]);
    assign wpos     = (pos_sum >= PW'(QUEUE_DEPTH)) ?
                      AW'(pos_sum - PW'(QUEUE_DEPTH)) : AW'(pos_sum);
    assign head_inc = (head[q] == AW'(QUEUE_DEPTH - 1)) ? '0 : head[q] + 1'b1;
    assign full     = (fill[q] == FW'(QUEUE_DEPTH));

    // saturating wait total
    assign sum_wide   = {1'b0, sum[q]} + {1'b0, wait_ext};
    assign sum_sat[q] = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];

    tcps_ram #(
      .WIDTH(EW),
      .DEPTH(QUEUE_DEPTH)
    ) u_ram (
      .clk  (clk),
      .we   (cmd.accept && arrives[q] && !full),
      .waddr(wpos),
      .wdata({next_id[q], tick, service[q]}),
      .re   (cmd.read),
      .raddr(head[q]),
      .rdata(rdata[q])
    );

    // queue bookkeeping; accept and finish never share a cycle
    always_ff @(posedge clk) begin
      if (rst) begin
        head[q]    <= '0;
        fill[q]    <= '0;
        next_id[q] <= ID_W'(1);
        count[q]   <= '0;
        sum[q]     <= '0;
      end else begin
        if (cmd.accept && arrives[q]) begin
          next_id[q] <= next_id[q] + 1'b1;
          if (!full) begin
            fill[q]  <= fill[q] + 1'b1;
            count[q] <= count[q] + 1'b1;
          end
        end
        if (cmd.finish && take[q]) begin
          head[q] <= head_inc;
          fill[q] <= fill[q] - 1'b1;
          sum[q]  <= sum_sat[q];
        end
      end
    end

    // drop flag of this word
    always_ff @(posedge clk) begin
      if (cmd.accept) begin
        dropped[q] <= arrives[q] && full;
      end
    end
  end

  // server state and tick
  logic [1:0]       class_new;
  logic [ID_W-1:0]  id_new;
  logic             start_new;
  always_comb begin
    class_new = cur_class;
    id_new    = cur_id;
    start_new = 1'b0;
    if (idle_srv) begin
      if (take[Q_PRIO] || take[Q_NORM]) begin
        class_new = take[Q_PRIO] ? CLASS_PRIO : CLASS_NORM;
        id_new    = sel[EW-1:TICK_BITS+SVC_W];
        start_new = 1'b1;
      end else begin
        class_new = CLASS_IDLE;
        id_new    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick      <= '0;
      remaining <= '0;
      cur_class <= CLASS_IDLE;
      cur_id    <= '0;
    end else if (cmd.finish) begin
      tick      <= tick + 1'b1;
      cur_class <= class_new;
      cur_id    <= id_new;
      remaining <= start_new ? sel[SVC_W-1:0] :
                   (idle_srv ? remaining : remaining - 1'b1);
    end
  end

  // output register
  assign sts.out_blocked = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_word.tick_now        <= tick_ext[OUT_TICK_W-1:0];
      out_word.serving_class   <= class_new;
      out_word.serving_id      <= id_new;
      out_word.started         <= start_new;
      out_word.start_wait      <= start_new ? wait_ext[OUT_TICK_W-1:0] : '0;
      out_word.prio_wait_total <= take[Q_PRIO] ? sum_sat[Q_PRIO] : sum[Q_PRIO];
      out_word.norm_wait_total <= take[Q_NORM] ? sum_sat[Q_NORM] : sum[Q_NORM];
      out_word.prio_count      <= count[Q_PRIO];
      out_word.norm_count      <= count[Q_NORM];
      out_word.prio_dropped    <= dropped[Q_PRIO];
      out_word.norm_dropped    <= dropped[Q_NORM];
    end
  end

endmodule

@@ hw/rtl/two_class_priority_server_unit.sv @@
// ----------------------------------------------------------------------------
// two_class_priority_server_unit
// Non-preemptive server in front of a priority queue and a normal queue.
// ----------------------------------------------------------------------------
// Each input word is one tick: an optional priority arrival and an optional
// normal arrival, each with a service length. Every input word gives exactly
// one output word with the tick, the server activity, any start and its wait,
// the running wait totals, accepted counts and drop flags.
// Input channel: in_valid / in_stall / in_word. Output channel: out_valid /
// out_stall / out_word. A word moves when valid is high and stall is low.
// Steps: a word passes the sequencer states accept (arrivals written into
// the queue RAMs), head read (registered RAM read) and server step, which
// loads the output register. The unit takes no new word until the server
// step of the last word is done; the sequencer, not the RAM ports, holds it.
// Reset: queues empty, tick 0, server idle, ids start at 1, totals and counts
// 0. The queue RAMs need no clearing pass.
// Receiver stall: the result waits in the output register. The next word is
// still accepted and read; its server step waits until the register frees.
// ----------------------------------------------------------------------------
module two_class_priority_server_unit
  import tcps_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int TICK_BITS   = DEF_TICK_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_word,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_word
);

  tcps_cmd_t cmd;
  tcps_sts_t sts;

  // sequencer
  tcps_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  // queues, server and output register
  tcps_dp #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .TICK_BITS  (TICK_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_word  (in_word),
    .cmd      (cmd),
    .sts      (sts),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  // a word just taken blocks the input until its step is done
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a word is in flight");

  // a start always names a class
  a_start_has_class: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.started) |-> (out_word.serving_class != CLASS_IDLE))
    else $error("start reported with idle server");

  // an idle server reports no id and no wait
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.serving_class == CLASS_IDLE) |->
      (out_word.serving_id == '0 && out_word.start_wait == '0))
    else $error("idle server reports an id or a wait");

  // a result word is loaded only from the server step, never from idle
  a_result_after_step: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.finish))
    else $error("result appeared without a server step");

endmodule
